// ===== src/word_value_table_search_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the word/value table search core
// Shared same-cycle-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef WORD_VALUE_TABLE_SEARCH_CORE_ASSERT_SVH
`define WORD_VALUE_TABLE_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define WVTS_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WVTS_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wvts_pkg.sv =====
// ----------------------------------------------------------------------------
// wvts_pkg
// Word types, codes and the microcode program of the table search core.
// ----------------------------------------------------------------------------
package wvts_pkg;

	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_KEY_CHARS     = 8;

	localparam int KEY_IN_W  = 64;
	localparam int VALUE_W   = 32;
	localparam int SLOT_W    = 8;
	localparam int CNT_W     = 9;
	localparam int POS_W     = CNT_W + 1;
	localparam int STEP_W    = CNT_W - 1;
	localparam int UPC_W     = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [7:0] CHAR_BELOW_A = 8'd64;
	localparam logic [7:0] CHAR_PAST_Z  = 8'd91;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_PROBE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 1'b1;

	typedef struct packed {
		logic                      cmd;
		logic [SLOT_W-1:0]         slot;
		logic [KEY_IN_W-1:0]       key;
		logic signed [VALUE_W-1:0] entry_value;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      found;
	} out_word_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_INIT,
		OP_RD,
		OP_UPD,
		OP_FIN,
		OP_WR
	} uop_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_WORD,
		C_LOAD,
		C_OOB,
		C_MORE,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		uop_t             op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		uop_t op;
		logic take;
	} ctl_t;

	typedef struct packed {
		logic is_load;
		logic oob;
		logic more;
		logic out_free;
	} stat_t;

	localparam logic [UPC_W-1:0] UA_IDLE  = 3'd0;
	localparam logic [UPC_W-1:0] UA_DISP  = 3'd1;
	localparam logic [UPC_W-1:0] UA_INIT  = 3'd2;
	localparam logic [UPC_W-1:0] UA_PROBE = 3'd3;
	localparam logic [UPC_W-1:0] UA_CMP   = 3'd4;
	localparam logic [UPC_W-1:0] UA_FIN   = 3'd5;
	localparam logic [UPC_W-1:0] UA_HOLD  = 3'd6;
	localparam logic [UPC_W-1:0] UA_WRITE = 3'd7;

	// Control store: jump to target when the condition holds, else fall through.
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucode_t w;
		unique case (upc)
			UA_IDLE:  w = '{op: OP_NOP,  cond: C_NO_WORD,  target: UA_IDLE};
			UA_DISP:  w = '{op: OP_NOP,  cond: C_LOAD,     target: UA_WRITE};
			UA_INIT:  w = '{op: OP_INIT, cond: C_NEVER,    target: UA_IDLE};
			UA_PROBE: w = '{op: OP_RD,   cond: C_OOB,      target: UA_FIN};
			UA_CMP:   w = '{op: OP_UPD,  cond: C_MORE,     target: UA_PROBE};
			UA_FIN:   w = '{op: OP_FIN,  cond: C_OUT_FREE, target: UA_IDLE};
			UA_HOLD:  w = '{op: OP_NOP,  cond: C_ALWAYS,   target: UA_FIN};
			UA_WRITE: w = '{op: OP_WR,   cond: C_ALWAYS,   target: UA_FIN};
			default:  w = '{op: OP_NOP,  cond: C_ALWAYS,   target: UA_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== src/word_value_table_search_core.sv =====
// ----------------------------------------------------------------------------
// word_value_table_search_core
// Word/value dictionary with linear or halving-probe key lookup.
// ----------------------------------------------------------------------------
// A load word writes one slot (keys lower-cased) and returns value 0, found 0.
// A lookup ends on a match, at the end of a probe search, or when the search
// steps past either end of the table; every linear miss and every lookup on an
// empty table ends the last way. A linear lookup makes up to entry_count key
// compares, and a probe lookup about log2(entry_count) compares plus a few.
// Each compare costs two steps of the microcode sequencer: one reads the key
// memory through its single registered read port, and one compares and moves.
// The finish step needs room in the output register. While an earlier result
// still waits there, the finish step retries by way of the hold step. One word
// is worked on at a time. in_ready rises together with out_valid when a result
// is registered, so the next word is taken while that result still waits in
// the output register. Configuration writes take effect at once; the user must
// make them only while the core is idle, and the core itself does not enforce
// this.
module word_value_table_search_core #(
	parameter int TABLE_ENTRIES = wvts_pkg::DEF_TABLE_ENTRIES,
	parameter int KEY_CHARS     = wvts_pkg::DEF_KEY_CHARS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  wvts_pkg::in_word_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output wvts_pkg::out_word_t                out_data,
	input  logic                               cfg_we,
	input  logic [wvts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wvts_pkg::CNT_W-1:0]         cfg_data
);
	import wvts_pkg::*;

	localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int KEY_W = 8 * KEY_CHARS;

	logic [CNT_W-1:0]          count_q;
	logic                      mode_q;

	ctl_t                      ctl;
	stat_t                     stat;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [KEY_W-1:0]          mem_wkey;
	logic signed [VALUE_W-1:0] mem_wval;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;
	logic [KEY_W-1:0]          mem_rkey;
	logic signed [VALUE_W-1:0] mem_rval;

	// configuration registers; entry count saturates at the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= MODE_PROBE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENTRY_COUNT: begin
					if (32'(cfg_data) > TABLE_ENTRIES)
						count_q <= CNT_W'(TABLE_ENTRIES);
					else
						count_q <= cfg_data;
				end
				CFG_SEARCH_MODE: mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	wvts_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	wvts_dp #(
		.ENTRIES   (TABLE_ENTRIES),
		.KEY_CHARS (KEY_CHARS),
		.KEY_W     (KEY_W),
		.AW        (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.in_data   (in_data),
		.mode      (mode_q),
		.count     (count_q),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wkey  (mem_wkey),
		.mem_wval  (mem_wval),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rkey  (mem_rkey),
		.mem_rval  (mem_rval),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	wvts_store #(
		.ENTRIES (TABLE_ENTRIES),
		.KEY_W   (KEY_W),
		.AW      (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wkey  (mem_wkey),
		.wval  (mem_wval),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rkey  (mem_rkey),
		.rval  (mem_rval)
	);

endmodule

// ===== src/wvts_store.sv =====
// ----------------------------------------------------------------------------
// wvts_store
// Key and value memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wvts_store #(
	parameter int ENTRIES = wvts_pkg::DEF_TABLE_ENTRIES,
	parameter int KEY_W   = 8 * wvts_pkg::DEF_KEY_CHARS,
	parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic [KEY_W-1:0]                   wkey,
	input  logic signed [wvts_pkg::VALUE_W-1:0] wval,
	input  logic                               re,
	input  logic [AW-1:0]                      raddr,
	output logic [KEY_W-1:0]                   rkey,
	output logic signed [wvts_pkg::VALUE_W-1:0] rval
);
	import wvts_pkg::*;

	logic [KEY_W-1:0]          key_mem [ENTRIES];
	logic signed [VALUE_W-1:0] val_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			val_mem[waddr] <= wval;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rkey <= key_mem[raddr];
			rval <= val_mem[raddr];
		end
	end

endmodule

// ===== src/wvts_useq.sv =====
// ----------------------------------------------------------------------------
// wvts_useq
// Microcode sequencer: step counter, control store and jump conditions.
// ----------------------------------------------------------------------------
`include "word_value_table_search_core_assert.svh"

module wvts_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wvts_pkg::stat_t stat,
	output wvts_pkg::ctl_t  ctl
);
	import wvts_pkg::*;

	logic [UPC_W-1:0] upc_q;
	ucode_t           uword;
	logic             jump;

	assign uword    = ucode_rom(upc_q);
	assign in_ready = (upc_q == UA_IDLE);
	assign ctl.op   = uword.op;
	assign ctl.take = in_valid && in_ready;

	always_comb begin
		unique case (uword.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_WORD:  jump = !in_valid;
			C_LOAD:     jump = stat.is_load;
			C_OOB:      jump = stat.oob;
			C_MORE:     jump = stat.more;
			C_OUT_FREE: jump = stat.out_free;
			default:    jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else if (jump) begin
			upc_q <= uword.target;
		end else begin
			upc_q <= upc_q + UPC_W'(1);
		end
	end

	`WVTS_ASSERT_NEXT(a_take_dispatch, clk, arst_n, ctl.take, upc_q == UA_DISP, "accepted word did not reach dispatch")
	`WVTS_ASSERT_IMPL(a_cmp_after_probe, clk, arst_n, upc_q == UA_CMP, $past(upc_q) == UA_PROBE, "compare step without a preceding read")

endmodule

// ===== src/wvts_dp.sv =====
// ----------------------------------------------------------------------------
// wvts_dp
// Search datapath: word capture, case folding, probe position and step,
// key compare, result register.
// ----------------------------------------------------------------------------
`include "word_value_table_search_core_assert.svh"

module wvts_dp #(
	parameter int ENTRIES   = wvts_pkg::DEF_TABLE_ENTRIES,
	parameter int KEY_CHARS = wvts_pkg::DEF_KEY_CHARS,
	parameter int KEY_W     = 8 * KEY_CHARS,
	parameter int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wvts_pkg::ctl_t                      ctl,
	output wvts_pkg::stat_t                     stat,
	input  wvts_pkg::in_word_t                  in_data,
	input  logic                                mode,
	input  logic [wvts_pkg::CNT_W-1:0]          count,
	output logic                                mem_we,
	output logic [AW-1:0]                       mem_waddr,
	output logic [KEY_W-1:0]                    mem_wkey,
	output logic signed [wvts_pkg::VALUE_W-1:0] mem_wval,
	output logic                                mem_re,
	output logic [AW-1:0]                       mem_raddr,
	input  logic [KEY_W-1:0]                    mem_rkey,
	input  logic signed [wvts_pkg::VALUE_W-1:0] mem_rval,
	output logic                                out_valid,
	input  logic                                out_ready,
	output wvts_pkg::out_word_t                 out_data
);
	import wvts_pkg::*;

	typedef enum logic [1:0] {
		LAST_NONE,
		LAST_UP,
		LAST_DOWN
	} last_t;

	// captured word
	logic                      cmd_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [KEY_W-1:0]          key_q;
	logic signed [VALUE_W-1:0] ev_q;

	// search state
	logic signed [POS_W-1:0]   pos_q;
	logic [STEP_W-1:0]         step_q;
	last_t                     last_q;
	logic                      hit_q;
	logic signed [VALUE_W-1:0] val_q;

	logic                      out_valid_q;
	out_word_t                 out_q;

	logic [KEY_W-1:0]          fold_key;
	logic                      fold_ended;
	logic [7:0]                fold_c;
	logic [7:0]                cmp_s;
	logic [7:0]                cmp_p;
	logic                      cmp_done;
	logic                      cmp_eq;
	logic                      cmp_gt;
	logic                      cmp_lt;
	logic                      stop;
	logic                      out_free;
	logic [CNT_W-1:0]          count_m1;
	logic signed [POS_W-1:0]   step_ext;
	logic signed [POS_W-1:0]   pos_up;
	logic signed [POS_W-1:0]   pos_dn;
	logic signed [POS_W-1:0]   pos_inc;

	// lower-case letters up to the first zero byte
	always_comb begin
		fold_key   = '0;
		fold_ended = 1'b0;
		fold_c     = '0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			fold_c = key_q[8*i +: 8];
			if (fold_c == 8'd0)
				fold_ended = 1'b1;
			if (!fold_ended && fold_c > CHAR_BELOW_A && fold_c < CHAR_PAST_Z)
				fold_c = fold_c + CASE_OFFSET;
			fold_key[8*i +: 8] = fold_c;
		end
	end

	// byte-wise order of stored key against probe key
	always_comb begin
		cmp_eq   = 1'b1;
		cmp_gt   = 1'b0;
		cmp_done = 1'b0;
		cmp_s    = '0;
		cmp_p    = '0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			cmp_s = mem_rkey[8*i +: 8];
			cmp_p = key_q[8*i +: 8];
			if (!cmp_done) begin
				if (cmp_s == 8'd0 && cmp_p == 8'd0) begin
					cmp_done = 1'b1;
				end else if (cmp_s != cmp_p) begin
					cmp_done = 1'b1;
					cmp_eq   = 1'b0;
					cmp_gt   = (cmp_s > cmp_p);
				end
			end
		end
	end

	assign cmp_lt   = !cmp_eq && !cmp_gt;
	assign count_m1 = count - CNT_W'(1);
	assign step_ext = $signed({{(POS_W - STEP_W){1'b0}}, step_q});
	assign pos_up   = pos_q + step_ext;
	assign pos_dn   = pos_q - step_ext;
	assign pos_inc  = pos_q + POS_W'(1);

	// a unit step that turns back ends the probe search
	assign stop = (mode == MODE_PROBE) && (step_q == STEP_W'(1)) &&
		((cmp_gt && last_q == LAST_UP) || (cmp_lt && last_q == LAST_DOWN));

	assign out_free      = !out_valid_q || out_ready;
	assign stat.is_load  = (cmd_q == CMD_LOAD);
	assign stat.oob      = pos_q[POS_W-1] || (pos_q[POS_W-2:0] >= count);
	assign stat.more     = !cmp_eq && !stop;
	assign stat.out_free = out_free;

	assign mem_we    = (ctl.op == OP_WR) && (32'(slot_q) < ENTRIES);
	assign mem_waddr = AW'(slot_q);
	assign mem_wkey  = fold_key;
	assign mem_wval  = ev_q;
	assign mem_re    = (ctl.op == OP_RD);
	assign mem_raddr = AW'($unsigned(pos_q));

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q  <= in_data.cmd;
			slot_q <= in_data.slot;
			key_q  <= in_data.key[KEY_W-1:0];
			ev_q   <= in_data.entry_value;
		end
		if (ctl.op == OP_UPD && cmp_eq)
			val_q <= mem_rval;
		if (ctl.op == OP_FIN && out_free) begin
			out_q.found <= hit_q;
			out_q.value <= hit_q ? val_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			step_q      <= '0;
			last_q      <= LAST_NONE;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_INIT: begin
					hit_q  <= 1'b0;
					last_q <= LAST_NONE;
					if (mode == MODE_LINEAR)
						pos_q <= '0;
					else
						pos_q <= $signed({1'b0, count}) - POS_W'(1);
					step_q <= (count_m1 == CNT_W'(1)) ? STEP_W'(1) :
						((STEP_W'(count_m1) == '0) ? STEP_W'(1) : STEP_W'(count_m1));
				end
				OP_RD: begin
					if (mode == MODE_PROBE && step_q != STEP_W'(1))
						step_q <= step_q >> 1;
				end
				OP_UPD: begin
					if (cmp_eq) begin
						hit_q <= 1'b1;
					end else if (mode == MODE_LINEAR) begin
						pos_q <= pos_inc;
					end else if (cmp_gt) begin
						if (step_q == STEP_W'(1))
							last_q <= LAST_DOWN;
						pos_q <= pos_dn;
					end else begin
						if (step_q == STEP_W'(1))
							last_q <= LAST_UP;
						pos_q <= pos_up;
					end
				end
				OP_WR: begin
					hit_q <= 1'b0;
				end
				default: begin
				end
			endcase

			if (ctl.op == OP_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`WVTS_ASSERT_IMPL(a_probe_in_range, clk, arst_n, ctl.op == OP_UPD, !pos_q[POS_W-1] && (pos_q[POS_W-2:0] < count), "compare at a position outside the table")
	`WVTS_ASSERT_IMPL(a_miss_zero_value, clk, arst_n, out_valid_q && !out_q.found, out_q.value == '0, "word without a match carries a nonzero value")

endmodule
